[hw/rtl/rhc_pkg.sv]
// Shared types, character codes and helpers for the record header classifier.
package rhc_pkg;

    localparam int NUM_DIGITS = 6;
    localparam int HDR_LAST   = NUM_DIGITS + 1;
    localparam int POS_W      = $clog2(HDR_LAST + 1);
    localparam int SEQ_W      = 20;
    localparam int ACC_W      = SEQ_W + 4;

    localparam logic [SEQ_W-1:0] SEQ_MAX = SEQ_W'(999999);

    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        KIND_D = 3'd0,
        KIND_R = 3'd1,
        KIND_Q = 3'd2,
        KIND_M = 3'd3,
        KIND_V = 3'd4,
        KIND_A = 3'd5,
        KIND_S = 3'd6,
        KIND_T = 3'd7
    } kind_t;

    typedef struct packed {
        logic [7:0] hdr_byte;
        logic       first_byte;
    } hdr_item_t;

    typedef struct packed {
        logic  known;
        kind_t kind;
    } letter_t;

    function automatic letter_t letter_code(input logic [7:0] c);
        letter_t r;
        r.known = 1'b1;
        case (c)
            CH_D:    r.kind = KIND_D;
            CH_R:    r.kind = KIND_R;
            CH_Q:    r.kind = KIND_Q;
            CH_M:    r.kind = KIND_M;
            CH_V:    r.kind = KIND_V;
            CH_A:    r.kind = KIND_A;
            CH_S:    r.kind = KIND_S;
            CH_T:    r.kind = KIND_T;
            default: begin
                r.known = 1'b0;
                r.kind  = KIND_D;
            end
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/record_header_classifier.sv]
// Top level of the record header classifier: input register, parser and result register.
// The last header byte item passes from the input register through the parser into the
// result register; a result held back downstream can stall it between the two registers.
// Throughput: one byte item per cycle; the input register takes a new item while a
// result waits, and stalls only when both the input and the result register are full.
// Reset (aresetn low, synchronous) empties both registers and re-arms parsing at byte zero.
module record_header_classifier (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_hdr_byte,
    input  logic                      s_first_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_kind_code,
    output logic                      m_continued,
    output logic [rhc_pkg::SEQ_W-1:0] m_seq_number,
    output logic                      m_bad_header
);
    import rhc_pkg::*;

    hdr_item_t s_item;
    hdr_item_t in_item;
    logic      in_valid;
    logic      in_take;

    assign s_item.hdr_byte   = s_hdr_byte;
    assign s_item.first_byte = s_first_byte;

    rhc_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .in_valid (in_valid),
        .in_take  (in_take),
        .in_item  (in_item)
    );

    rhc_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (in_valid),
        .in_take      (in_take),
        .in_item      (in_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind_code  (m_kind_code),
        .m_continued  (m_continued),
        .m_seq_number (m_seq_number),
        .m_bad_header (m_bad_header)
    );

    // A bad header carries no type, flag or number.
    a_bad_clears_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_header) |-> (m_kind_code == KIND_D && !m_continued
                                       && m_seq_number == '0))
        else $error("bad header item carries nonzero fields");

    a_seq_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_seq_number <= SEQ_MAX))
        else $error("sequence number above its maximum");

    // Only the types V, A, S and T may be continued.
    a_cont_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_continued) |-> (!m_bad_header && m_kind_code[2]))
        else $error("continuation on a type that cannot be continued");

    // The input side stalls only while a result is held back downstream.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && in_valid))
        else $error("input stalled without a held result");

endmodule

[hw/rtl/rhc_in_stage.sv]
// Input register that holds one header byte item until the parser takes it.
module rhc_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rhc_pkg::hdr_item_t s_item,
    output logic               in_valid,
    input  logic               in_take,
    output rhc_pkg::hdr_item_t in_item
);
    import rhc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    hdr_item_t item_reg;

    assign s_ready  = !valid_reg || in_take;
    assign in_valid = valid_reg;
    assign in_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (in_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

[hw/rtl/rhc_parser.sv]
// Header parse state, classification logic and result register.
module rhc_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_take,
    input  rhc_pkg::hdr_item_t         in_item,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_kind_code,
    output logic                       m_continued,
    output logic [rhc_pkg::SEQ_W-1:0]  m_seq_number,
    output logic                       m_bad_header
);
    import rhc_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [SEQ_W-1:0] accum_reg, accum_next;
    logic             neg_reg, neg_next;
    logic             seen_reg, seen_next;
    logic             err_reg, err_next;
    logic [7:0]       type_reg, type_next;
    logic             done_reg, done_next;

    logic             out_valid_reg, out_valid_next;
    logic [2:0]       kind_reg, kind_next;
    logic             cont_reg, cont_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic             bad_reg, bad_next;

    logic [POS_W-1:0] pos_eff;
    logic [SEQ_W-1:0] accum_eff;
    logic             neg_eff, seen_eff, err_eff, done_eff;
    logic [7:0]       type_eff;
    logic [7:0]       c;
    logic [ACC_W-1:0] acc_wide;
    letter_t          letter;
    logic             bad;
    logic             cont;
    logic             adv;

    assign adv     = !out_valid_reg || m_ready;
    assign in_take = in_valid && adv;
    assign c       = in_item.hdr_byte;
    assign letter  = letter_code(type_eff);

    assign m_valid      = out_valid_reg;
    assign m_kind_code  = kind_reg;
    assign m_continued  = cont_reg;
    assign m_seq_number = seq_reg;
    assign m_bad_header = bad_reg;

    always_comb begin
        if (in_item.first_byte) begin
            pos_eff   = '0;
            accum_eff = '0;
            neg_eff   = 1'b0;
            seen_eff  = 1'b0;
            err_eff   = 1'b0;
            type_eff  = '0;
            done_eff  = 1'b0;
        end else begin
            pos_eff   = pos_reg;
            accum_eff = accum_reg;
            neg_eff   = neg_reg;
            seen_eff  = seen_reg;
            err_eff   = err_reg;
            type_eff  = type_reg;
            done_eff  = done_reg;
        end

        acc_wide = (ACC_W'(accum_eff) << 3) + (ACC_W'(accum_eff) << 1)
                 + ACC_W'(c - CH_ZERO);

        pos_next   = pos_eff;
        accum_next = accum_eff;
        neg_next   = neg_eff;
        seen_next  = seen_eff;
        err_next   = err_eff;
        type_next  = type_eff;
        done_next  = done_eff;

        out_valid_next = out_valid_reg && !m_ready;
        kind_next      = kind_reg;
        cont_next      = cont_reg;
        seq_next       = seq_reg;
        bad_next       = bad_reg;

        bad  = err_eff || (neg_eff && (accum_eff != '0));
        cont = 1'b0;
        if (c == CH_SPACE) begin
            if (!letter.known) begin
                bad = 1'b1;
            end
        end else if (c == CH_STAR) begin
            cont = 1'b1;
            if (!letter.known || !letter.kind[2]) begin
                bad = 1'b1;
            end
        end else begin
            bad = 1'b1;
        end

        if (in_take && !done_eff) begin
            if (pos_eff < POS_W'(NUM_DIGITS)) begin
                pos_next = pos_eff + 1'b1;
                if ((pos_eff == '0) && (c == CH_MINUS)) begin
                    neg_next = 1'b1;
                end else if (c inside {[CH_ZERO:CH_NINE]}) begin
                    accum_next = (acc_wide > ACC_W'(SEQ_MAX)) ? SEQ_MAX
                                                              : acc_wide[SEQ_W-1:0];
                    seen_next  = 1'b1;
                end else if ((c == CH_PLUS) && !seen_eff) begin
                    seen_next = 1'b1;
                end else if ((c != CH_SPACE) || seen_eff) begin
                    err_next = 1'b1;
                end
            end else if (pos_eff == POS_W'(NUM_DIGITS)) begin
                type_next = c;
                pos_next  = pos_eff + 1'b1;
            end else begin
                done_next      = 1'b1;
                out_valid_next = 1'b1;
                bad_next       = bad;
                kind_next      = bad ? KIND_D : letter.kind;
                cont_next      = bad ? 1'b0 : cont;
                seq_next       = bad ? '0 : accum_eff;
            end
        end else if (in_take) begin
            pos_next   = pos_eff;
            accum_next = accum_eff;
            neg_next   = neg_eff;
            seen_next  = seen_eff;
            err_next   = err_eff;
            type_next  = type_eff;
            done_next  = done_eff;
        end else begin
            pos_next   = pos_reg;
            accum_next = accum_reg;
            neg_next   = neg_reg;
            seen_next  = seen_reg;
            err_next   = err_reg;
            type_next  = type_reg;
            done_next  = done_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            accum_reg     <= '0;
            neg_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            err_reg       <= 1'b0;
            type_reg      <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            accum_reg     <= accum_next;
            neg_reg       <= neg_next;
            seen_reg      <= seen_next;
            err_reg       <= err_next;
            type_reg      <= type_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
        kind_reg <= kind_next;
        cont_reg <= cont_next;
        seq_reg  <= seq_next;
        bad_reg  <= bad_next;
    end

endmodule
